/* hw/rtl/alkp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package alkp_pkg;

    // Fixed geometry of the block.
    localparam int MAX_KEYS = 4;
    localparam int KEY_W    = 2;
    localparam int ADC_BITS = 10;
    localparam int HOLD_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Input commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Event kinds.
    localparam logic [2:0] EV_PRESS      = 3'd0;
    localparam logic [2:0] EV_RELEASE    = 3'd1;
    localparam logic [2:0] EV_TAP        = 3'd2;
    localparam logic [2:0] EV_LONG_START = 3'd3;
    localparam logic [2:0] EV_LONG_END   = 3'd4;
    localparam logic [2:0] EV_CLICK      = 3'd5;

    // Key modes; the fourth code behaves as plain.
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_LONG  = 2'd1;
    localparam logic [1:0] MODE_CLICK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODES     = 3'd6;

    // Configuration reset values.
    localparam logic [ADC_BITS-1:0] DRIFT_RESET     = 10'd70;
    localparam logic [HOLD_W-1:0]   THRESHOLD_RESET = 8'd88;

    typedef struct packed {
        logic                command;
        logic                sample_valid;
        logic [ADC_BITS-1:0] adc_sample;
    } req_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic [2:0]       event_kind;
        logic             last_event;
    } evt_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_TICK,
        ST_FLUSH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_item;
        logic             sample_step;
        logic             tick_step;
        logic             flush;
        logic [KEY_W-1:0] key_idx;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/adc_ladder_key_long_press_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Resistor-ladder keypad qualifier with long-press detection. A sample item
// (command 0) matches the ADC reading against each enabled key centre and
// arms keys whose level differs from their debounced state; it gives no
// events and walks K = min(NUM_KEYS, 4) keys, one key per cycle through the
// shared window comparator. A tick item (command 1) walks the same keys one
// per cycle while the event output is not stalled, then passes a flush step;
// the walk waits while a held event cannot leave for the event stall. Events
// leave through an output register, the last one of a tick flagged by
// last_event; a new item is accepted only once the walk is done.
// Configuration writes are taken at any time but are meant for idle periods.
module adc_ladder_key_long_press_unit
    import alkp_pkg::*;
#(
    parameter int NUM_KEYS = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire req_item_t             req,
    output logic                       evt_valid,
    input  wire logic                  evt_stall,
    output evt_item_t                  evt,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer over the keys.
    alkp_ctrl #(
        .NUM_KEYS (NUM_KEYS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req.command),
        .req_stall   (req_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // Key state, configuration and event output.
    alkp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule

`default_nettype wire

/* hw/rtl/alkp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module alkp_ctrl
    import alkp_pkg::*;
#(
    parameter int NUM_KEYS = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    input  wire logic       req_command,
    output logic            req_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam int ACTIVE_KEYS = (NUM_KEYS < MAX_KEYS) ? NUM_KEYS : MAX_KEYS;
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(ACTIVE_KEYS - 1);

    ctrl_state_t      state_reg, state_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             accept;

    assign accept = req_valid && (state_reg == ST_IDLE);

    // State and key counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            key_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    // Next state: walk the keys once per item, one key a cycle unless the event output stalls a tick.
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        case (state_reg)
            ST_IDLE:
            begin
                key_next = '0;
                if (accept)
                begin
                    state_next = (req_command == CMD_TICK) ? ST_TICK : ST_SAMPLE;
                end
            end
            ST_SAMPLE:
            begin
                if (key_reg == LAST_KEY)
                begin
                    state_next = ST_IDLE;
                    key_next   = '0;
                end
                else
                begin
                    key_next = key_reg + 1'b1;
                end
            end
            ST_TICK:
            begin
                if (status.slot_free)
                begin
                    if (key_reg == LAST_KEY)
                    begin
                        state_next = ST_FLUSH;
                        key_next   = '0;
                    end
                    else
                    begin
                        key_next = key_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                key_next   = '0;
            end
        endcase
    end

    // Outputs: commands to the datapath and the input stall.
    always_comb
    begin
        req_stall       = (state_reg != ST_IDLE);
        cmd.load_item   = accept;
        cmd.sample_step = 1'b0;
        cmd.tick_step   = 1'b0;
        cmd.flush       = 1'b0;
        cmd.key_idx     = key_reg;
        case (state_reg)
            ST_IDLE:   cmd.load_item   = accept;
            ST_SAMPLE: cmd.sample_step = 1'b1;
            ST_TICK:   cmd.tick_step   = status.slot_free;
            ST_FLUSH:  cmd.flush       = status.slot_free;
            default:   cmd.load_item   = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/alkp_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module alkp_datapath
    import alkp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire req_item_t             req,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    output logic                       evt_valid,
    input  wire logic                  evt_stall,
    output evt_item_t                  evt
);

    // Configuration registers.
    logic [ADC_BITS-1:0] drift_reg;
    logic [HOLD_W-1:0]   thr_reg;
    logic [ADC_BITS-1:0] center_reg [MAX_KEYS];
    logic [7:0]          modes_reg;

    // Captured input item.
    logic                sv_reg;
    logic [ADC_BITS-1:0] adc_reg;

    // Per-key state.
    logic [MAX_KEYS-1:0] matched_reg;
    logic [MAX_KEYS-1:0] deb_reg;
    logic [MAX_KEYS-1:0] armed_reg;
    logic [MAX_KEYS-1:0] pend_reg;
    logic [HOLD_W-1:0]   hold_reg [MAX_KEYS];

    // Held event and output register.
    logic             held_valid_reg;
    logic [KEY_W-1:0] held_key_reg;
    logic [2:0]       held_kind_reg;
    logic             evt_valid_reg;
    evt_item_t        evt_reg;

    // Per-key working values.
    logic [KEY_W-1:0]    k;
    logic [ADC_BITS-1:0] c;
    logic [ADC_BITS:0]   sum_hi, sum_lo;
    logic                match;
    logic [1:0]          mode;
    logic                lvl, deb, pend;
    logic [HOLD_W-1:0]   hold, hold_sat;
    logic                ev_fire;
    logic [2:0]          ev_kind;
    logic [HOLD_W-1:0]   hold_next;
    logic                pend_next;
    logic                slot_free;

    assign k         = cmd.key_idx;
    assign slot_free = !evt_valid_reg || !evt_stall;
    assign status.slot_free = slot_free;
    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_reg <= DRIFT_RESET;
            thr_reg   <= THRESHOLD_RESET;
            for (int i = 0; i < MAX_KEYS; i++)
            begin
                center_reg[i] <= '0;
            end
            modes_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DRIFT:     drift_reg     <= cfg_data[ADC_BITS-1:0];
                CFG_THRESHOLD: thr_reg       <= cfg_data[HOLD_W-1:0];
                CFG_KEY0:      center_reg[0] <= cfg_data[ADC_BITS-1:0];
                CFG_KEY1:      center_reg[1] <= cfg_data[ADC_BITS-1:0];
                CFG_KEY2:      center_reg[2] <= cfg_data[ADC_BITS-1:0];
                CFG_KEY3:      center_reg[3] <= cfg_data[ADC_BITS-1:0];
                CFG_MODES:     modes_reg     <= cfg_data[7:0];
                default:       drift_reg     <= drift_reg;
            endcase
        end
    end

    // Capture the sample fields of an accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            sv_reg  <= req.sample_valid;
            adc_reg <= req.adc_sample;
        end
    end

    // Window match: center - drift < sample < center + drift, without signs.
    always_comb
    begin
        c      = center_reg[k];
        sum_hi = {1'b0, c} + {1'b0, drift_reg};
        sum_lo = {1'b0, adc_reg} + {1'b0, drift_reg};
        match  = sv_reg && ({1'b0, adc_reg} < sum_hi) && (sum_lo > {1'b0, c});
    end

    // Qualify the selected key for a tick.
    always_comb
    begin
        mode      = modes_reg[2*k +: 2];
        lvl       = matched_reg[k];
        deb       = deb_reg[k];
        pend      = pend_reg[k];
        hold      = hold_reg[k];
        hold_sat  = (hold == '1) ? hold : hold + 1'b1;
        ev_fire   = 1'b0;
        ev_kind   = EV_PRESS;
        hold_next = hold;
        pend_next = pend;
        if (deb != lvl)
        begin
            if (mode == MODE_CLICK)
            begin
                ev_fire = 1'b1;
                ev_kind = EV_CLICK;
            end
            else if (mode == MODE_LONG)
            begin
                // Both edges restart the count at one.
                hold_next = HOLD_W'(1);
                pend_next = lvl;
                if (!lvl)
                begin
                    ev_fire = 1'b1;
                    ev_kind = (hold > thr_reg) ? EV_LONG_END : EV_TAP;
                end
            end
            else
            begin
                ev_fire = 1'b1;
                ev_kind = lvl ? EV_PRESS : EV_RELEASE;
            end
        end
        else if (mode == MODE_LONG)
        begin
            hold_next = hold_sat;
            if (pend && (hold_sat > thr_reg))
            begin
                pend_next = 1'b0;
                ev_fire   = 1'b1;
                ev_kind   = EV_LONG_START;
            end
        end
    end

    // Per-key state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= '0;
            deb_reg     <= '0;
            armed_reg   <= '0;
            pend_reg    <= '0;
            for (int i = 0; i < MAX_KEYS; i++)
            begin
                hold_reg[i] <= '0;
            end
        end
        else if (cmd.sample_step)
        begin
            if (c != '0)
            begin
                matched_reg[k] <= match;
                if (deb_reg[k] != match)
                begin
                    armed_reg[k] <= 1'b1;
                end
            end
        end
        else if (cmd.tick_step && armed_reg[k])
        begin
            armed_reg[k] <= lvl;
            deb_reg[k]   <= lvl;
            pend_reg[k]  <= pend_next;
            hold_reg[k]  <= hold_next;
        end
    end

    // One event is held back until it is known whether another follows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.tick_step && armed_reg[k] && ev_fire)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                held_valid_reg <= 1'b0;
            end

            if ((cmd.tick_step && armed_reg[k] && ev_fire && held_valid_reg)
                || (cmd.flush && held_valid_reg))
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (!evt_stall)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    // Held event and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.tick_step && armed_reg[k] && ev_fire)
        begin
            held_key_reg  <= k;
            held_kind_reg <= ev_kind;
        end
        if ((cmd.tick_step && armed_reg[k] && ev_fire && held_valid_reg)
            || (cmd.flush && held_valid_reg))
        begin
            evt_reg.key_index  <= held_key_reg;
            evt_reg.event_kind <= held_kind_reg;
            evt_reg.last_event <= cmd.flush;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_adc_ladder_key_long_press_unit.sv */
`timescale 1ns / 1ps

module tb_adc_ladder_key_long_press_unit;
    import alkp_pkg::*;

    localparam int BY_MODEL        = -1;
    localparam int ITEMS_PER_PHASE = 12;
    localparam int RAND_PHASES     = 5;
    localparam int PRESSURE_ROW    = 10;
    localparam int SETTLE_CYCLES   = 16;
    localparam int LONG_TICKS      = 24;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int MAX_REPORTS     = 10;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    // Fourth mode code, which behaves as plain.
    localparam logic [1:0] MODE_ALT = 2'd3;
    localparam evt_item_t NO_EV = '0;

    typedef struct {
        bit        reconfig;
        req_item_t item;
        int        n_typed;
        evt_item_t ev0;
        evt_item_t ev1;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_item_t             req;
    logic                  evt_valid;
    logic                  evt_stall;
    evt_item_t             evt;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Register copies kept beside the block.
    logic [ADC_BITS-1:0] win_cfg;
    logic [HOLD_W-1:0]   thr_cfg;
    logic [ADC_BITS-1:0] center_cfg [MAX_KEYS];
    logic [7:0]          modes_cfg;

    // Per-key qualifier state.
    bit                lvl_q  [MAX_KEYS];
    bit                deb_q  [MAX_KEYS];
    bit                arm_q  [MAX_KEYS];
    bit                pend_q [MAX_KEYS];
    logic [HOLD_W-1:0] hold_q [MAX_KEYS];

    evt_item_t events_due [$];
    plan_row_t dir_plan [$];
    int        mismatches = 0;
    bit        calm = 1'b0;
    bit        hold_evt = 1'b0;

    adc_ladder_key_long_press_unit #(
        .NUM_KEYS (MAX_KEYS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic evt_item_t mk_ev(input int k, input logic [2:0] kind, input logic last);
        evt_item_t e;
        e.key_index  = k[KEY_W-1:0];
        e.event_kind = kind;
        e.last_event = last;
        return e;
    endfunction

    function automatic req_item_t mk_req(input logic cmd, input logic vld, input int adc);
        req_item_t r;
        r.command      = cmd;
        r.sample_valid = vld;
        r.adc_sample   = adc[ADC_BITS-1:0];
        return r;
    endfunction

    function automatic logic [HOLD_W-1:0] sat_inc(input logic [HOLD_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Works out the events that one item causes and advances the key state.
    task automatic qualify(input req_item_t it, output evt_item_t evs[$]);
        int         c;
        int         d;
        int         s;
        logic [1:0] mode;
        bit         lvl;
        evt_item_t  e;
        evs = {};
        if (it.command == CMD_SAMPLE)
        begin
            s = int'(it.adc_sample);
            d = int'(win_cfg);
            for (int k = 0; k < MAX_KEYS; k++)
            begin
                c = int'(center_cfg[k]);
                // A key with centre zero is disabled and keeps its level.
                if (c != 0)
                begin
                    lvl_q[k] = it.sample_valid && (s < c + d) && (s > c - d);
                    if (deb_q[k] != lvl_q[k])
                        arm_q[k] = 1'b1;
                end
            end
        end
        else
        begin
            for (int k = 0; k < MAX_KEYS; k++)
            begin
                if (arm_q[k])
                begin
                    mode     = modes_cfg[2*k +: 2];
                    arm_q[k] = 1'b0;
                    lvl      = lvl_q[k];
                    if (deb_q[k] != lvl)
                    begin
                        deb_q[k] = lvl;
                        if (mode == MODE_CLICK)
                            evs.push_back(mk_ev(k, EV_CLICK, 1'b0));
                        else if (mode == MODE_LONG)
                        begin
                            if (!lvl)
                            begin
                                pend_q[k] = 1'b0;
                                evs.push_back(mk_ev(k, (hold_q[k] > thr_cfg) ? EV_LONG_END
                                                                             : EV_TAP, 1'b0));
                            end
                            else
                                pend_q[k] = 1'b1;
                            hold_q[k] = sat_inc('0);
                        end
                        else
                            evs.push_back(mk_ev(k, lvl ? EV_PRESS : EV_RELEASE, 1'b0));
                    end
                    else if (mode == MODE_LONG)
                    begin
                        // Long start is only checked on ticks without a level change.
                        hold_q[k] = sat_inc(hold_q[k]);
                        if (pend_q[k] && hold_q[k] > thr_cfg)
                        begin
                            pend_q[k] = 1'b0;
                            evs.push_back(mk_ev(k, EV_LONG_START, 1'b0));
                        end
                    end
                    if (lvl)
                        arm_q[k] = 1'b1;
                end
            end
            if (evs.size() > 0)
            begin
                e = evs.pop_back();
                e.last_event = 1'b1;
                evs.push_back(e);
            end
        end
    endtask

    // Offers one item, waits until it is taken and queues its events.
    task automatic send_item(input req_item_t it, input int typed,
                             input evt_item_t t0, input evt_item_t t1);
        int        gap;
        evt_item_t got [$];
        gap = calm ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (req_stall);
        qualify(it, got);
        if (typed == BY_MODEL)
        begin
            foreach (got[i])
                events_due.push_back(got[i]);
        end
        else
        begin
            if (typed > 0)
                events_due.push_back(t0);
            if (typed > 1)
                events_due.push_back(t1);
        end
    endtask

    task automatic offer(input req_item_t it);
        send_item(it, BY_MODEL, NO_EV, NO_EV);
    endtask

    function automatic req_item_t tick_item();
        return mk_req(CMD_TICK, 1'($urandom_range(0, 1)), $urandom_range(0, 1023));
    endfunction

    // A valid sample inside or just at the edge of a random key's window, or anywhere if that key or the drift is zero.
    function automatic req_item_t near_key();
        int k;
        int c;
        int d;
        int off;
        int s;
        k = $urandom_range(0, MAX_KEYS - 1);
        c = int'(center_cfg[k]);
        d = int'(win_cfg);
        if (c == 0 || d == 0)
            return mk_req(CMD_SAMPLE, 1'b1, $urandom_range(0, 1023));
        if ($urandom_range(0, 3) == 0)
            off = d - int'($urandom_range(0, 1));
        else
            off = $urandom_range(0, d - 1);
        s = $urandom_range(0, 1) ? c + off : c - off;
        if (s < 0)
            s = 0;
        if (s > 1023)
            s = 1023;
        return mk_req(CMD_SAMPLE, 1'b1, s);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            CFG_DRIFT:     win_cfg       = val[ADC_BITS-1:0];
            CFG_THRESHOLD: thr_cfg       = val[HOLD_W-1:0];
            CFG_KEY0:      center_cfg[0] = val[ADC_BITS-1:0];
            CFG_KEY1:      center_cfg[1] = val[ADC_BITS-1:0];
            CFG_KEY2:      center_cfg[2] = val[ADC_BITS-1:0];
            CFG_KEY3:      center_cfg[3] = val[ADC_BITS-1:0];
            CFG_MODES:     modes_cfg     = val[7:0];
            default:       ;
        endcase
    endtask

    task automatic load_setup(input int drift, input int thr, input int c0, input int c1,
                              input int c2, input int c3, input int modes);
        write_reg(CFG_DRIFT, drift);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_KEY0, c0);
        write_reg(CFG_KEY1, c1);
        write_reg(CFG_KEY2, c2);
        write_reg(CFG_KEY3, c3);
        write_reg(CFG_MODES, modes);
        write_reg(CFG_SPARE, $urandom_range(0, 1023));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Lets every expected event drain and a sample walk finish.
    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_row(input bit recfg, input logic cmd, input logic vld, input int adc,
                           input int n, input evt_item_t e0, input evt_item_t e1);
        plan_row_t row;
        row.reconfig = recfg;
        row.item     = mk_req(cmd, vld, adc);
        row.n_typed  = n;
        row.ev0      = e0;
        row.ev1      = e1;
        dir_plan.push_back(row);
    endtask

    // Event side: random stalls per item, with one long hold-off on request.
    initial
    begin : evt_sink
        int gap;
        evt_stall = 1'b0;
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 7);
            if (hold_evt)
            begin
                gap      = HOLD_OFF_CYCLES;
                hold_evt = 1'b0;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                evt_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            evt_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(evt_valid && !evt_stall));
        end
    end

    // Compare each accepted event with the oldest one expected.
    always @(posedge clk)
    begin : evt_check
        evt_item_t want;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (events_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected event: key %0d kind %0d last %0d",
                             evt.key_index, evt.event_kind, evt.last_event);
            end
            else
            begin
                want = events_due.pop_front();
                if (evt.key_index !== want.key_index || evt.event_kind !== want.event_kind
                    || evt.last_event !== want.last_event)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: want %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.key_index, want.event_kind, want.last_event,
                                 evt.key_index, evt.event_kind, evt.last_event);
                end
            end
        end
    end

    initial
    begin : watchdog
        #4000000;
        $display("tb_adc_ladder_key_long_press_unit: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int drift;
        int thr;
        int cen [MAX_KEYS];
        int modes;
        int n;
        int r;
        int run;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        win_cfg   = DRIFT_RESET;
        thr_cfg   = THRESHOLD_RESET;
        modes_cfg = '0;
        for (int k = 0; k < MAX_KEYS; k++)
        begin
            center_cfg[k] = '0;
            hold_q[k]     = '0;
        end

        // Directed plan: reset behavior, every event kind, window edges.
        add_row(0, CMD_TICK,   0, 0,    0, NO_EV, NO_EV);
        add_row(0, CMD_SAMPLE, 1, 1023, 0, NO_EV, NO_EV);
        add_row(1, CMD_SAMPLE, 1, 100,  0, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   1, 1023, 1, mk_ev(0, EV_PRESS, 1), NO_EV);
        add_row(0, CMD_TICK,   0, 0,    0, NO_EV, NO_EV);
        add_row(0, CMD_SAMPLE, 1, 300,  0, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   1, 512,  1, mk_ev(0, EV_RELEASE, 1), NO_EV);
        add_row(0, CMD_TICK,   0, 0,    BY_MODEL, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   1, 0,    1, mk_ev(1, EV_LONG_START, 1), NO_EV);
        add_row(0, CMD_SAMPLE, 1, 600,  0, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   0, 0,    2, mk_ev(1, EV_LONG_END, 0), mk_ev(2, EV_CLICK, 1));
        add_row(0, CMD_SAMPLE, 1, 900,  0, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   1, 1023, 2, mk_ev(2, EV_CLICK, 0), mk_ev(3, EV_PRESS, 1));
        add_row(0, CMD_SAMPLE, 0, 900,  0, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   0, 0,    1, mk_ev(3, EV_RELEASE, 1), NO_EV);
        add_row(0, CMD_SAMPLE, 1, 300,  0, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   0, 0,    BY_MODEL, NO_EV, NO_EV);
        add_row(0, CMD_SAMPLE, 1, 0,    0, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   0, 0,    1, mk_ev(1, EV_TAP, 1), NO_EV);
        add_row(0, CMD_SAMPLE, 1, 170,  BY_MODEL, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   0, 0,    BY_MODEL, NO_EV, NO_EV);
        add_row(0, CMD_SAMPLE, 1, 169,  BY_MODEL, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   1, 341,  BY_MODEL, NO_EV, NO_EV);
        add_row(0, CMD_SAMPLE, 1, 30,   BY_MODEL, NO_EV, NO_EV);
        add_row(0, CMD_TICK,   0, 0,    BY_MODEL, NO_EV, NO_EV);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_plan[i])
        begin
            if (dir_plan[i].reconfig)
            begin
                wait_idle();
                load_setup(70, 2, 100, 300, 600, 900,
                           int'({MODE_ALT, MODE_CLICK, MODE_LONG, MODE_PLAIN}));
            end
            // The receiver holds off here so that the block backs up.
            if (i == PRESSURE_ROW)
                hold_evt = 1'b1;
            send_item(dir_plan[i].item, dir_plan[i].n_typed, dir_plan[i].ev0, dir_plan[i].ev1);
        end

        // Random phases, each under its own setting of the registers.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            wait_idle();
            drift = (p == 1) ? 0 : (p == 2) ? 1023 : (p == 3) ? 1 : $urandom_range(20, 120);
            thr   = (p == 3) ? 0 : $urandom_range(0, 6);
            for (int k = 0; k < MAX_KEYS; k++)
                cen[k] = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 1023);
            if (p == 2)
            begin
                cen[0] = 1;
                cen[3] = 1023;
            end
            modes = $urandom_range(0, 255);
            load_setup(drift, thr, cen[0], cen[1], cen[2], cen[3], modes);
            calm = (p == 2);
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    run = $urandom_range(1, 4);
                    repeat (run) offer(tick_item());
                    n += run;
                end
                else
                begin
                    if (r < 85)
                        offer(near_key());
                    else
                        offer(mk_req(CMD_SAMPLE, 1'($urandom_range(0, 1)),
                                     $urandom_range(0, 1023)));
                    n++;
                end
            end
            calm = 1'b0;
        end

        // Hold one long-press key past a threshold well above the random ones.
        wait_idle();
        load_setup(70, 20, 500, 0, 0, 0, int'(MODE_LONG));
        offer(mk_req(CMD_SAMPLE, 1'b1, 500));
        repeat (LONG_TICKS) offer(tick_item());
        offer(mk_req(CMD_SAMPLE, 1'b0, 500));
        offer(tick_item());

        wait_idle();
        if (mismatches == 0)
            $display("tb_adc_ladder_key_long_press_unit: done, clean");
        else
            $display("tb_adc_ladder_key_long_press_unit: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/alkp_pkg.sv
hw/rtl/alkp_ctrl.sv
hw/rtl/alkp_datapath.sv
hw/rtl/adc_ladder_key_long_press_unit.sv
tb/sv/tb_adc_ladder_key_long_press_unit.sv
